/* sv/logfmt_pair_scanner_unit_defines.svh */
// Assertion macros for the checker file of the pair scanner.
`ifndef LOGFMT_PAIR_SCANNER_UNIT_DEFINES_SVH
`define LOGFMT_PAIR_SCANNER_UNIT_DEFINES_SVH

// Antecedent in this cycle implies consequent in the same cycle.
`define LPS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define LPS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/lps_pkg.sv */
// Types and character constants shared by the logfmt pair scanner modules.
`timescale 1ns / 1ps

package lps_pkg;

  localparam logic [7:0] CH_COMMA      = 8'h2C;
  localparam logic [7:0] CH_SEMI       = 8'h3B;
  localparam logic [7:0] CH_EQUALS     = 8'h3D;
  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_DASH       = 8'h2D;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_DIGIT_LO   = 8'h30;
  localparam logic [7:0] CH_DIGIT_HI   = 8'h39;
  localparam logic [7:0] CH_UPPER_LO   = 8'h41;
  localparam logic [7:0] CH_UPPER_HI   = 8'h5A;
  localparam logic [7:0] CH_LOWER_LO   = 8'h61;
  localparam logic [7:0] CH_LOWER_HI   = 8'h7A;

  localparam logic [11:0] TALLY_MAX = 12'hFFF;

  typedef enum logic [2:0] {
    PH_SEEK,
    PH_KEY,
    PH_VSTART,
    PH_BARE,
    PH_QOPEN,
    PH_QBODY
  } phase_t;

  typedef struct packed {
    logic word;
    logic key_byte;
    logic bare_byte;
    logic equals;
    logic quote;
  } char_class_t;

  typedef struct packed {
    logic        produce;
    logic        pair_valid;
    logic [11:0] key_offset;
    logic [12:0] key_length;
    logic [11:0] value_offset;
    logic [12:0] value_length;
    logic        line_end;
    logic [11:0] pairs_so_far;
    logic        line_overflow;
  } scan_result_t;

endpackage

/* sv/lps_char_class.sv */
// Character class decode for one input byte.
`timescale 1ns / 1ps

module lps_char_class (
  input  logic [7:0]          char_byte,
  output lps_pkg::char_class_t cls
);
  import lps_pkg::*;

  logic word;
  logic ws;

  always_comb begin
    word = (char_byte inside {[CH_DIGIT_LO:CH_DIGIT_HI], [CH_UPPER_LO:CH_UPPER_HI],
                              [CH_LOWER_LO:CH_LOWER_HI], CH_UNDERSCORE});
    ws   = (char_byte inside {CH_SPACE, [CH_TAB:CH_CR]});
    cls.word      = word;
    cls.key_byte  = word || (char_byte == CH_DOT) || (char_byte == CH_DASH);
    cls.bare_byte = !ws && (char_byte != CH_COMMA) && (char_byte != CH_SEMI);
    cls.equals    = (char_byte == CH_EQUALS);
    cls.quote     = (char_byte == CH_QUOTE);
  end

endmodule

/* sv/lps_scan_core.sv */
// Scan state machine: line position, key/value tracking and result formation.
`timescale 1ns / 1ps

module lps_scan_core #(
  parameter int MAX_LINE = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  logic [7:0]            char_byte,
  input  logic                  line_last,
  output lps_pkg::scan_result_t res
);
  import lps_pkg::*;

  localparam int POS_W  = $clog2(MAX_LINE + 1);
  localparam int OFF_W  = $clog2(MAX_LINE);
  localparam int WIDE_W = (POS_W > 13) ? POS_W : 13;
  localparam logic [POS_W-1:0] POS_MAX  = POS_W'(MAX_LINE);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_LINE - 1);
  localparam logic [OFF_W-1:0] OFF_MAX  = OFF_W'(MAX_LINE - 1);

  char_class_t cls;

  phase_t            phase, phase_next;
  logic [POS_W-1:0]  pos;
  logic [OFF_W-1:0]  key_begin, key_begin_next;
  logic [POS_W-1:0]  key_span, key_span_next;
  logic [OFF_W-1:0]  value_begin, value_begin_next;
  logic [11:0]       tally, tally_next;
  logic              ovf, ovf_next;

  logic              at_max, at_last_off, emit;
  logic [POS_W-1:0]  pos_inc, end_incl, vend, vlen;
  logic [OFF_W-1:0]  off, off_after;
  logic [WIDE_W-1:0] wide_koff, wide_klen, wide_voff, wide_vlen;

  lps_char_class u_class (
    .char_byte (char_byte),
    .cls       (cls)
  );

  always_comb begin
    at_max      = (pos == POS_MAX);
    at_last_off = (pos >= POS_LAST);
    pos_inc     = pos + POS_W'(1);
    end_incl    = at_max ? pos : pos_inc;
    off         = at_last_off ? OFF_MAX : pos[OFF_W-1:0];
    off_after   = at_last_off ? OFF_MAX : pos_inc[OFF_W-1:0];
    ovf_next    = ovf | at_max;

    phase_next       = phase;
    key_begin_next   = key_begin;
    key_span_next    = key_span;
    value_begin_next = value_begin;
    emit             = 1'b0;
    vend             = '0;

    case (phase)
      PH_SEEK: begin
        if (cls.word) begin
          key_begin_next = off;
          phase_next     = PH_KEY;
        end
      end
      PH_KEY: begin
        if (cls.key_byte) begin
          phase_next = PH_KEY;
        end else if (cls.equals) begin
          key_span_next = pos - POS_W'(key_begin);
          phase_next    = PH_VSTART;
        end else begin
          phase_next = PH_SEEK;
        end
      end
      PH_VSTART: begin
        if (cls.quote) begin
          value_begin_next = off_after;
          phase_next       = PH_QOPEN;
        end else if (cls.bare_byte) begin
          value_begin_next = off;
          phase_next       = PH_BARE;
          emit             = line_last;
          vend             = end_incl;
        end else begin
          phase_next = PH_SEEK;
        end
      end
      PH_BARE: begin
        if (cls.bare_byte) begin
          emit = line_last;
          vend = end_incl;
        end else begin
          emit       = 1'b1;
          vend       = pos;
          phase_next = PH_SEEK;
        end
      end
      PH_QOPEN: begin
        if (cls.quote) begin
          phase_next = PH_SEEK;
        end else begin
          phase_next = PH_QBODY;
          emit       = line_last;
          vend       = end_incl;
        end
      end
      PH_QBODY: begin
        if (cls.quote) begin
          emit       = 1'b1;
          vend       = pos;
          phase_next = PH_SEEK;
        end else begin
          emit = line_last;
          vend = end_incl;
        end
      end
      default: begin
        phase_next = PH_SEEK;
      end
    endcase

    tally_next = (emit && (tally != TALLY_MAX)) ? tally + 12'd1 : tally;
    vlen       = vend - POS_W'(value_begin_next);

    wide_koff = WIDE_W'(key_begin_next);
    wide_klen = WIDE_W'(key_span_next);
    wide_voff = WIDE_W'(value_begin_next);
    wide_vlen = WIDE_W'(vlen);

    res.produce       = emit || line_last;
    res.pair_valid    = emit;
    res.key_offset    = emit ? wide_koff[11:0] : 12'd0;
    res.key_length    = emit ? wide_klen[12:0] : 13'd0;
    res.value_offset  = emit ? wide_voff[11:0] : 12'd0;
    res.value_length  = emit ? wide_vlen[12:0] : 13'd0;
    res.line_end      = line_last;
    res.pairs_so_far  = tally_next;
    res.line_overflow = ovf_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SEEK;
      pos         <= '0;
      key_begin   <= '0;
      key_span    <= '0;
      value_begin <= '0;
      tally       <= '0;
      ovf         <= 1'b0;
    end else if (take) begin
      // the last byte closes the line: return everything to its start values
      if (line_last) begin
        phase       <= PH_SEEK;
        pos         <= '0;
        key_begin   <= '0;
        key_span    <= '0;
        value_begin <= '0;
        tally       <= '0;
        ovf         <= 1'b0;
      end else begin
        phase       <= phase_next;
        pos         <= end_incl;
        key_begin   <= key_begin_next;
        key_span    <= key_span_next;
        value_begin <= value_begin_next;
        tally       <= tally_next;
        ovf         <= ovf_next;
      end
    end
  end

endmodule

/* sv/logfmt_pair_scanner_unit.sv */
// Top level of the logfmt pair scanner: input register, scan core, result register.
//
//  channel | dir | payload
//  s_*     | in  | tdata[7:0] char_byte, tlast line_last
//  m_*     | out | tdata key/value offsets, lengths, pairs_so_far; tlast line_end;
//          |     | tuser pair_valid, line_overflow
//
// One byte is taken every cycle unless stalled as below; path: input register, result register.
// A byte that yields no result passes through the scan core even while m_* is stalled.
// A byte that yields a result waits in the input register while the result register is full.
// rst is synchronous and clears both registers and all line state; no clearing pass.
`timescale 1ns / 1ps

module logfmt_pair_scanner_unit #(
  parameter int MAX_LINE = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // key_offset, key_length, value_offset, value_length,
                                 // pairs_so_far, zero pad
  output logic        m_tlast,
  output logic [1:0]  m_tuser    // pair_valid, line_overflow
);
  import lps_pkg::*;

  logic         in_valid;
  logic [7:0]   in_char;
  logic         in_last;
  logic         take;
  logic         slot_free;
  scan_result_t res;

  lps_scan_core #(
    .MAX_LINE (MAX_LINE)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .char_byte (in_char),
    .line_last (in_last),
    .res       (res)
  );

  assign slot_free = !m_tvalid || m_tready;
  assign take      = in_valid && (!res.produce || slot_free);
  assign s_tready  = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (take) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata;
      in_last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take && res.produce) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res.produce) begin
      m_tdata <= {2'b00, res.pairs_so_far, res.value_length, res.value_offset,
                  res.key_length, res.key_offset};
      m_tlast <= res.line_end;
      m_tuser <= {res.line_overflow, res.pair_valid};
    end
  end

endmodule

/* sv/lps_checker.sv */
// Port-level checks on the pair scanner results, bound to the top level.
`timescale 1ns / 1ps
`include "logfmt_pair_scanner_unit_defines.svh"

module lps_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tlast,
  input logic [1:0]  m_tuser
);

  // hold a stalled result
  `LPS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped under stall")
  // a result without a pair only closes a line
  `LPS_ASSERT_NOW(a_bare_is_end, m_tvalid && !m_tuser[0], m_tlast, "empty result not at line end")
  // a result without a pair carries zero offsets and lengths
  `LPS_ASSERT_NOW(a_empty_zero, m_tvalid && !m_tuser[0], m_tdata[49:0] == 50'd0,
                  "empty result has nonzero fields")
  // a pair is counted in its own tally
  `LPS_ASSERT_NOW(a_pair_counted, m_tvalid && m_tuser[0], m_tdata[61:50] != 12'd0,
                  "pair with zero tally")

endmodule

bind logfmt_pair_scanner_unit lps_checker u_lps_checker (.*);

/* verif/tb_logfmt_pair_scanner_unit.sv */
// Self-checking testbench for the logfmt pair scanner: directed rows and random lines.
`timescale 1ns / 1ps

module tb_logfmt_pair_scanner_unit;
  import lps_pkg::*;

  localparam int LINE_CAP   = 4096;
  localparam int DIR_ROWS   = 25;
  localparam int RAND_ITEMS = 675;
  localparam int TIMEOUT_NS = 20 * 600000;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;

  typedef struct packed {
    logic        pair_valid;
    logic [11:0] key_off;
    logic [12:0] key_len;
    logic [11:0] val_off;
    logic [12:0] val_len;
    logic        line_end;
    logic [11:0] pairs;
    logic        ovf;
  } pair_res_t;

  // One input byte; typed rows carry their expected result in want.
  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       typed;
    pair_res_t  want;
  } byte_item_t;

  localparam pair_res_t NO_RES = '0;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;
  logic        m_tlast;
  logic [1:0]  m_tuser;

  byte_item_t  dir_tab [DIR_ROWS];
  byte_item_t  stim [$];
  pair_res_t   pending_results [$];
  int          errs;
  int          sent;
  bit          calm;

  string key_chars = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_.-";

  // Scanner state mirrored by the predictor.
  phase_t      sc_phase;
  int          sc_pos;
  int          sc_key_at;
  int          sc_key_len;
  int          sc_val_at;
  int          sc_tally;
  bit          sc_ovf;

  logfmt_pair_scanner_unit #(
    .MAX_LINE(LINE_CAP)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Some tests failed");
    $finish;
  end

  function automatic bit is_word(input logic [7:0] c);
    return (c >= CH_DIGIT_LO && c <= CH_DIGIT_HI) || (c >= CH_UPPER_LO && c <= CH_UPPER_HI) ||
           (c >= CH_LOWER_LO && c <= CH_LOWER_HI) || c == CH_UNDERSCORE;
  endfunction

  function automatic bit is_key(input logic [7:0] c);
    return is_word(c) || c == CH_DOT || c == CH_DASH;
  endfunction

  function automatic bit is_bare(input logic [7:0] c);
    return !(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) && c != CH_COMMA && c != CH_SEMI;
  endfunction

  function automatic int clamp_off(input int i);
    return (i < LINE_CAP - 1) ? i : LINE_CAP - 1;
  endfunction

  function automatic int clamp_end(input int i);
    return (i < LINE_CAP) ? i : LINE_CAP;
  endfunction

  function automatic void clear_line_state();
    sc_phase   = PH_SEEK;
    sc_pos     = 0;
    sc_key_at  = 0;
    sc_key_len = 0;
    sc_val_at  = 0;
    sc_tally   = 0;
    sc_ovf     = 1'b0;
  endfunction

  function automatic pair_res_t mk(input int pv, input int ko, input int kl, input int vo,
                                   input int vl, input int le, input int ps, input int ov);
    pair_res_t r;
    r.pair_valid = pv[0];
    r.key_off    = ko[11:0];
    r.key_len    = kl[12:0];
    r.val_off    = vo[11:0];
    r.val_len    = vl[12:0];
    r.line_end   = le[0];
    r.pairs      = ps[11:0];
    r.ovf        = ov[0];
    return r;
  endfunction

  // Advance the scanner by one byte; return 1 when the byte yields a result.
  function automatic bit scan_byte(input logic [7:0] c, input bit last, output pair_res_t r);
    int idx;
    int off;
    int end_b;
    int end_i;
    int vend;
    bit emit;
    idx  = sc_pos;
    emit = 1'b0;
    vend = 0;
    r    = '0;
    if (idx >= LINE_CAP) sc_ovf = 1'b1;
    off   = clamp_off(idx);
    end_b = clamp_end(idx);
    end_i = clamp_end(idx + 1);
    case (sc_phase)
      PH_SEEK: begin
        if (is_word(c)) begin
          sc_key_at = off;
          sc_phase  = PH_KEY;
        end
      end
      PH_KEY: begin
        if (!is_key(c)) begin
          if (c == CH_EQUALS) begin
            sc_key_len = end_b - sc_key_at;
            sc_phase   = PH_VSTART;
          end else begin
            sc_phase = PH_SEEK;
          end
        end
      end
      PH_VSTART: begin
        if (c == CH_QUOTE) begin
          sc_val_at = clamp_off(idx + 1);
          sc_phase  = PH_QOPEN;
        end else if (is_bare(c)) begin
          sc_val_at = off;
          sc_phase  = PH_BARE;
          if (last) begin
            emit = 1'b1;
            vend = end_i;
          end
        end else begin
          sc_phase = PH_SEEK;
        end
      end
      PH_BARE: begin
        if (is_bare(c)) begin
          if (last) begin
            emit = 1'b1;
            vend = end_i;
          end
        end else begin
          emit     = 1'b1;
          vend     = end_b;
          sc_phase = PH_SEEK;
        end
      end
      PH_QOPEN: begin
        if (c == CH_QUOTE) begin
          sc_phase = PH_SEEK;
        end else begin
          sc_phase = PH_QBODY;
          if (last) begin
            emit = 1'b1;
            vend = end_i;
          end
        end
      end
      PH_QBODY: begin
        if (c == CH_QUOTE) begin
          emit     = 1'b1;
          vend     = end_b;
          sc_phase = PH_SEEK;
        end else if (last) begin
          emit = 1'b1;
          vend = end_i;
        end
      end
      default: sc_phase = PH_SEEK;
    endcase
    sc_pos = end_i;
    if (emit && sc_tally < TALLY_MAX) sc_tally++;
    if (!emit && !last) return 1'b0;
    if (emit) r = mk(1, sc_key_at, sc_key_len, sc_val_at, vend - sc_val_at, 0, 0, 0);
    r.line_end = last;
    r.pairs    = sc_tally[11:0];
    r.ovf      = sc_ovf;
    if (last) clear_line_state();
    return 1'b1;
  endfunction

  function automatic string fmt_res(input pair_res_t r);
    return $sformatf("pv=%0d ko=%0d kl=%0d vo=%0d vl=%0d end=%0d n=%0d ovf=%0d",
                     r.pair_valid, r.key_off, r.key_len, r.val_off, r.val_len,
                     r.line_end, r.pairs, r.ovf);
  endfunction

  task automatic push(input logic [7:0] b, input bit last);
    byte_item_t it;
    it      = '0;
    it.b    = b;
    it.last = last;
    stim.insert(stim.size(), it);
  endtask

  task automatic push_key(input int n);
    push(key_chars[$urandom_range(0, 62)], 1'b0);
    repeat (n - 1) push(key_chars[$urandom_range(0, 64)], 1'b0);
  endtask

  task automatic push_bare(input int n);
    logic [7:0] c;
    repeat (n) begin
      do c = 8'($urandom_range(0, 255)); while (!is_bare(c));
      push(c, 1'b0);
    end
  endtask

  task automatic push_quoted(input int n);
    logic [7:0] c;
    repeat (n) begin
      do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE);
      push(c, 1'b0);
    end
  endtask

  task automatic mark_line_end();
    stim[stim.size() - 1].last = 1'b1;
  endtask

  // Result side: stall at random, check every transaction against the oldest expectation.
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      m_tready <= calm || ($urandom_range(0, 99) >= 13);
    end
  end

  always @(posedge clk) begin
    pair_res_t got;
    pair_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.pair_valid = m_tuser[0];
      got.key_off    = m_tdata[11:0];
      got.key_len    = m_tdata[24:12];
      got.val_off    = m_tdata[36:25];
      got.val_len    = m_tdata[49:37];
      got.pairs      = m_tdata[61:50];
      got.line_end   = m_tlast;
      got.ovf        = m_tuser[1];
      if (pending_results.size() == 0) begin
        errs++;
        if (errs <= 10) $display("unexpected result: %s", fmt_res(got));
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          errs++;
          if (errs <= 10) begin
            $display("mismatch expected: %s", fmt_res(want));
            $display("         actual:   %s", fmt_res(got));
          end
        end
      end
    end
  end

  initial begin
    int         ntok;
    int         kind;
    logic [7:0] c;
    pair_res_t  r;
    bit         hit;

    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    errs = 0;
    sent = 0;
    calm = 1'b0;
    clear_line_state();

    dir_tab = '{
      // bare pair closed by the line end, right after reset
      {"a", 1'b0, 1'b0, NO_RES},
      {CH_EQUALS, 1'b0, 1'b0, NO_RES},
      {"1", 1'b1, 1'b1, mk(1, 0, 1, 2, 1, 1, 1, 0)},
      // line end inside a key: no pair
      {"k", 1'b1, 1'b1, mk(0, 0, 0, 0, 0, 1, 0, 0)},
      // empty value, key with dot and dash, bare value starting with '=', quoted value
      {"x", 1'b0, 1'b0, NO_RES},
      {CH_EQUALS, 1'b0, 1'b0, NO_RES},
      {CH_SEMI, 1'b0, 1'b0, NO_RES},
      {CH_UNDERSCORE, 1'b0, 1'b0, NO_RES},
      {CH_DOT, 1'b0, 1'b0, NO_RES},
      {CH_DASH, 1'b0, 1'b0, NO_RES},
      {CH_EQUALS, 1'b0, 1'b0, NO_RES},
      {CH_EQUALS, 1'b0, 1'b0, NO_RES},
      {"2", 1'b0, 1'b0, NO_RES},
      {CH_COMMA, 1'b0, 1'b0, NO_RES},
      {"Z", 1'b0, 1'b0, NO_RES},
      {CH_EQUALS, 1'b0, 1'b0, NO_RES},
      {CH_QUOTE, 1'b0, 1'b0, NO_RES},
      {"q", 1'b0, 1'b0, NO_RES},
      {CH_QUOTE, 1'b1, 1'b0, NO_RES},
      // top byte, then a key whose unterminated quoted value is closed by the line end
      {8'hFF, 1'b0, 1'b0, NO_RES},
      {"b", 1'b0, 1'b0, NO_RES},
      {CH_EQUALS, 1'b0, 1'b0, NO_RES},
      {CH_QUOTE, 1'b0, 1'b0, NO_RES},
      {"c", 1'b1, 1'b0, NO_RES},
      // zero byte as a one-byte line
      {8'h00, 1'b1, 1'b1, mk(0, 0, 0, 0, 0, 1, 0, 0)}
    };
    foreach (dir_tab[i]) stim.insert(stim.size(), dir_tab[i]);

    // Random lines: mostly well-formed pairs, with empty values, broken keys and noise.
    while (stim.size() < DIR_ROWS + RAND_ITEMS) begin
      ntok = $urandom_range(1, 5);
      repeat (ntok) begin
        kind = $urandom_range(0, 15);
        if (kind < 7) begin
          push_key($urandom_range(1, 5));
          push(CH_EQUALS, 1'b0);
          push_bare($urandom_range(1, 6));
        end else if (kind < 10) begin
          push_key($urandom_range(1, 5));
          push(CH_EQUALS, 1'b0);
          push(CH_QUOTE, 1'b0);
          push_quoted($urandom_range(0, 6));
          push(CH_QUOTE, 1'b0);
        end else if (kind == 10) begin
          push_key($urandom_range(1, 3));
          push(CH_EQUALS, 1'b0);
        end else if (kind == 11) begin
          push_key($urandom_range(1, 3));
        end else if (kind == 12) begin
          push_key($urandom_range(1, 3));
          do c = 8'($urandom_range(0, 255)); while (is_key(c) || c == CH_EQUALS);
          push(c, 1'b0);
        end else begin
          repeat ($urandom_range(1, 4)) push(8'($urandom_range(0, 255)), 1'b0);
        end
        case ($urandom_range(0, 7))
          0: push(CH_SPACE, 1'b0);
          1: push(CH_TAB, 1'b0);
          2: push(CH_COMMA, 1'b0);
          3: push(CH_SEMI, 1'b0);
          4: push(CH_CR, 1'b0);
          5: push(CH_LF, 1'b0);
          6: push(CH_VT, 1'b0);
          default: push(CH_FF, 1'b0);
        endcase
      end
      // End the line inside a value, right after '=', or on the separator.
      case ($urandom_range(0, 3))
        0: begin
          push_key($urandom_range(1, 4));
          push(CH_EQUALS, 1'b0);
          push_bare($urandom_range(1, 4));
        end
        1: begin
          push_key($urandom_range(1, 4));
          push(CH_EQUALS, 1'b0);
          push(CH_QUOTE, 1'b0);
          push_quoted($urandom_range(0, 4));
        end
        2: begin
          push_key($urandom_range(1, 4));
          push(CH_EQUALS, 1'b0);
        end
        default: ;
      endcase
      mark_line_end();
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (sent < stim.size()) begin
      @(posedge clk);
      if (s_tvalid && s_tready) begin
        hit = scan_byte(stim[sent].b, stim[sent].last, r);
        if (hit) pending_results.insert(pending_results.size(),
                                        stim[sent].typed ? stim[sent].want : r);
        sent++;
      end
      calm = (sent >= 300 && sent < 500);
      // Hold a transaction until it is taken; otherwise offer the next byte or idle.
      if (!s_tvalid || s_tready) begin
        if (sent < stim.size() && (calm || $urandom_range(0, 99) >= 13)) begin
          s_tvalid <= 1'b1;
          s_tdata  <= stim[sent].b;
          s_tlast  <= stim[sent].last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end

    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    errs += pending_results.size();
    if (errs == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/lps_pkg.sv
sv/lps_char_class.sv
sv/lps_scan_core.sv
sv/logfmt_pair_scanner_unit.sv
sv/lps_checker.sv
verif/tb_logfmt_pair_scanner_unit.sv
